FILE: rtl/core/rotenc_pkg.sv
// Shared types and codes for the detented rotary encoder decoder.
// Request and result item structs, command codes, pin patterns and event codes.
// No dependencies.
package rotenc_pkg;

	// command codes
	localparam logic [1:0] CMD_CLK_EDGE  = 2'd0;
	localparam logic [1:0] CMD_DATA_EDGE = 2'd1;
	localparam logic [1:0] CMD_SWITCH    = 2'd2;
	localparam logic [1:0] CMD_SCAN      = 2'd3;

	// sampled pin patterns: bit0 clock pin, bit1 data pin
	localparam logic [1:0] PINS_CLK_ONLY  = 2'b01;
	localparam logic [1:0] PINS_DATA_ONLY = 2'b10;
	localparam logic [1:0] PINS_BOTH      = 2'b11;

	// event codes
	localparam logic [1:0] EV_NONE  = 2'd0;
	localparam logic [1:0] EV_INC   = 2'd1;
	localparam logic [1:0] EV_DEC   = 2'd2;
	localparam logic [1:0] EV_PRESS = 2'd3;

	localparam int unsigned DEBOUNCE_W = 16;
	localparam int unsigned POS_W      = 16;
	localparam int unsigned TIME_W     = 32;

	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd50;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [1:0]        pin_levels;
		logic              button_level;
		logic [TIME_W-1:0] now_ms;
	} req_item_t;

	typedef struct packed {
		logic [1:0]              event_res;
		logic signed [POS_W-1:0] position;
	} rsp_item_t;

endpackage

FILE: rtl/core/rotary_encoder_detent_decoder_core.sv
// Detented rotary encoder decoder with push switch: top level.
// Request register, decoder state (rotenc_detent) and result register.
// Depends on rotenc_pkg and rotenc_detent.
//
// Usage:
//   Requests arrive on req_valid/req_ready/req_item; each carries a command
//   (clock-line edge, data-line edge, switch changed, scan) with pin levels,
//   button level and millisecond time. Every request yields exactly one result
//   on rsp_valid/rsp_ready/rsp_item: an event code (nonzero only for scans)
//   and the position count after the request.
//   A request is accepted into the request register and moves on to the
//   result register when that register is free or being emptied.
//   Throughput: one request per cycle while results are taken; the state update
//   for a request is a single 16-bit step and one 32-bit subtract and compare,
//   done in the cycle the request leaves the request register.
//   The debounce window is written through cfg_we/cfg_wdata; the user must
//   write it only while idle, which the block does not enforce. Reset: all
//   decoder state clears to zero, debounce window to 50 ms, both channels go empty.
//   Stall: a held result keeps its register; one more request waits in the
//   request register, after which req_ready drops until rsp_ready returns.
module rotary_encoder_detent_decoder_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  rotenc_pkg::req_item_t             req_item,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output rotenc_pkg::rsp_item_t             rsp_item,
	input  logic                              cfg_we,
	input  logic [rotenc_pkg::DEBOUNCE_W-1:0] cfg_wdata
);

	logic                              vld_s1;
	rotenc_pkg::req_item_t             req_s1;
	logic                              rsp_vld_q;
	rotenc_pkg::rsp_item_t             rsp_q;
	rotenc_pkg::rsp_item_t             result;
	logic [rotenc_pkg::DEBOUNCE_W-1:0] debounce_q;
	logic                              adv;
	logic                              fire;

	// result register free or being emptied this cycle
	assign adv       = !rsp_vld_q || rsp_ready;
	assign fire      = vld_s1 && adv;
	assign req_ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= rotenc_pkg::DEBOUNCE_RESET;
		end else if (cfg_we) begin
			debounce_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req_ready) begin
			vld_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req_item;
		end
	end

	rotenc_detent u_detent (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.item     (req_s1),
		.debounce (debounce_q),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (adv) begin
			rsp_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_vld_q;
	assign rsp_item  = rsp_q;

`ifndef NO_ASSERTIONS
	// only a scan may report an event
	a_event_scan_only: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && req_s1.cmd != rotenc_pkg::CMD_SCAN) |->
			result.event_res == rotenc_pkg::EV_NONE)
		else $error("event reported for a non-scan request");

	// a request leaving the request register shows up as a result next cycle
	a_fire_to_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> rsp_valid)
		else $error("result lost after request register");

	// an accepted request always lands in the request register
	a_accept_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> vld_s1)
		else $error("accepted request dropped");
`endif

endmodule

FILE: rtl/core/rotenc_detent.sv
// Decoder state and per-request update logic: position counter, detent expect flags,
// last-seen position, press timestamp and pending switch flag.
// Depends on rotenc_pkg.
module rotenc_detent (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   fire,
	input  rotenc_pkg::req_item_t                  item,
	input  logic [rotenc_pkg::DEBOUNCE_W-1:0]      debounce,
	output rotenc_pkg::rsp_item_t                  result
);

	logic [rotenc_pkg::POS_W-1:0]  pos_q, pos_d;
	logic [rotenc_pkg::POS_W-1:0]  last_pos_q, last_pos_d;
	logic [rotenc_pkg::TIME_W-1:0] press_time_q, press_time_d;
	logic [rotenc_pkg::TIME_W-1:0] elapsed;
	logic                          exp_clk_q, exp_clk_d;
	logic                          exp_data_q, exp_data_d;
	logic                          sw_pend_q, sw_pend_d;
	logic [1:0]                    ev;

	assign elapsed = item.now_ms - press_time_q;

	always_comb begin
		pos_d        = pos_q;
		last_pos_d   = last_pos_q;
		press_time_d = press_time_q;
		exp_clk_d    = exp_clk_q;
		exp_data_d   = exp_data_q;
		sw_pend_d    = sw_pend_q;
		ev           = rotenc_pkg::EV_NONE;
		unique case (item.cmd)
			rotenc_pkg::CMD_CLK_EDGE: begin
				if (item.pin_levels == rotenc_pkg::PINS_BOTH && exp_clk_q) begin
					pos_d      = pos_q - 1'b1;
					exp_clk_d  = 1'b0;
					exp_data_d = 1'b0;
				end else if (item.pin_levels == rotenc_pkg::PINS_CLK_ONLY) begin
					exp_data_d = 1'b1;
				end
			end
			rotenc_pkg::CMD_DATA_EDGE: begin
				if (item.pin_levels == rotenc_pkg::PINS_BOTH && exp_data_q) begin
					pos_d      = pos_q + 1'b1;
					exp_clk_d  = 1'b0;
					exp_data_d = 1'b0;
				end else if (item.pin_levels == rotenc_pkg::PINS_DATA_ONLY) begin
					exp_clk_d = 1'b1;
				end
			end
			rotenc_pkg::CMD_SWITCH: begin
				sw_pend_d = 1'b1;
			end
			rotenc_pkg::CMD_SCAN: begin
				// signed compare: a step across the wrap reads as the other direction
				if (pos_q != last_pos_q) begin
					ev = ($signed(last_pos_q) < $signed(pos_q)) ?
						rotenc_pkg::EV_INC : rotenc_pkg::EV_DEC;
				end
				last_pos_d = pos_q;
				if (!item.button_level) begin
					if (elapsed > {{(rotenc_pkg::TIME_W-rotenc_pkg::DEBOUNCE_W){1'b0}},
						debounce} && sw_pend_q) begin
						ev        = rotenc_pkg::EV_PRESS;
						sw_pend_d = 1'b0;
					end
					// every low scan restarts the debounce window
					press_time_d = item.now_ms;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			last_pos_q   <= '0;
			press_time_q <= '0;
			exp_clk_q    <= 1'b0;
			exp_data_q   <= 1'b0;
			sw_pend_q    <= 1'b0;
		end else if (fire) begin
			pos_q        <= pos_d;
			last_pos_q   <= last_pos_d;
			press_time_q <= press_time_d;
			exp_clk_q    <= exp_clk_d;
			exp_data_q   <= exp_data_d;
			sw_pend_q    <= sw_pend_d;
		end
	end

	assign result.event_res = ev;
	assign result.position  = $signed(pos_d);

endmodule

FILE: tb/tb_top.sv
// Testbench for rotary_encoder_detent_decoder_core: directed table, then random
// detent/scan/switch traffic under four debounce windows, checked by a predictor.
// Depends on rotenc_pkg and the decoder RTL.
module tb_top;
	import rotenc_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned PHASE_ITEMS = 390;

	typedef struct {
		bit        typed;
		rsp_item_t want;
	} preset_t;

	typedef struct {
		req_item_t req;
		bit        typed;
		rsp_item_t want;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  req_valid;
	logic                  req_ready;
	req_item_t             req_item;
	logic                  rsp_valid;
	logic                  rsp_ready;
	rsp_item_t             rsp_item;
	logic                  cfg_we;
	logic [DEBOUNCE_W-1:0] cfg_wdata;

	// decoder state as predicted
	logic [DEBOUNCE_W-1:0] window_ms;
	logic [POS_W-1:0]      pos_count;
	logic                  want_clk_detent;
	logic                  want_data_detent;
	logic [POS_W-1:0]      seen_pos;
	logic [TIME_W-1:0]     last_low_ms;
	logic                  switch_pend;

	rsp_item_t   pending_rsp_q[$];
	preset_t     preset_q[$];
	dir_row_t    dir_rows[$];
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;
	int unsigned req_sent = 0;
	bit          gaps_on = 1'b0;
	bit          hold_long = 1'b0;
	logic [TIME_W-1:0] scan_clock = '0;

	rotary_encoder_detent_decoder_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_item  (req_item),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_item  (rsp_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic rsp_item_t decode_step(input req_item_t it);
		rsp_item_t         r;
		logic [TIME_W-1:0] elapsed;
		r.event_res = EV_NONE;
		case (it.cmd)
			CMD_CLK_EDGE: begin
				if (it.pin_levels == PINS_BOTH && want_clk_detent) begin
					pos_count = pos_count - 1'b1;
					want_clk_detent = 1'b0;
					want_data_detent = 1'b0;
				end else if (it.pin_levels == PINS_CLK_ONLY) begin
					want_data_detent = 1'b1;
				end
			end
			CMD_DATA_EDGE: begin
				if (it.pin_levels == PINS_BOTH && want_data_detent) begin
					pos_count = pos_count + 1'b1;
					want_clk_detent = 1'b0;
					want_data_detent = 1'b0;
				end else if (it.pin_levels == PINS_DATA_ONLY) begin
					want_clk_detent = 1'b1;
				end
			end
			CMD_SWITCH: begin
				switch_pend = 1'b1;
			end
			default: begin
				// signed compare: a step across the wrap reads as the opposite direction
				if (pos_count != seen_pos)
					r.event_res = ($signed(seen_pos) < $signed(pos_count)) ? EV_INC : EV_DEC;
				seen_pos = pos_count;
				if (!it.button_level) begin
					elapsed = it.now_ms - last_low_ms;
					if (elapsed > {16'd0, window_ms} && switch_pend) begin
						r.event_res = EV_PRESS;
						switch_pend = 1'b0;
					end
					last_low_ms = it.now_ms;
				end
			end
		endcase
		r.position = pos_count;
		return r;
	endfunction

	// request acceptance and result checking
	always @(posedge clk) begin : monitor
		rsp_item_t want;
		preset_t   p;
		if (arst_n) begin
			if (cfg_we)
				window_ms = cfg_wdata;
			if (req_valid && req_ready) begin
				want = decode_step(req_item);
				p = preset_q.pop_front();
				pending_rsp_q.push_back(p.typed ? p.want : want);
			end
			if (rsp_valid && rsp_ready) begin
				if (pending_rsp_q.size() == 0) begin
					$error("unexpected result: event_res %0d position %0d",
						rsp_item.event_res, rsp_item.position);
					fail_count++;
				end else begin
					want = pending_rsp_q.pop_front();
					if (rsp_item.event_res !== want.event_res) begin
						$error("event_res: expected %0d, got %0d",
							want.event_res, rsp_item.event_res);
						fail_count++;
					end
					if (rsp_item.position !== want.position) begin
						$error("position: expected %0d, got %0d",
							want.position, rsp_item.position);
						fail_count++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// result side: random stall bursts, plus one long hold-off on request
	initial begin
		rsp_ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_long) begin
				rsp_ready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_long = 1'b0;
			end else if (gaps_on && $urandom_range(0, 7) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end else begin
				rsp_ready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end
	end

	task automatic offer(input req_item_t it, input bit typed, input rsp_item_t want);
		preset_t p;
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		p.typed = typed;
		p.want = want;
		preset_q.push_back(p);
		req_valid <= 1'b1;
		req_item <= it;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		req_sent++;
	endtask

	function automatic req_item_t mk_req(input logic [1:0] cmd, input logic [1:0] pins,
		input logic btn, input logic [TIME_W-1:0] now);
		req_item_t it;
		it.cmd = cmd;
		it.pin_levels = pins;
		it.button_level = btn;
		it.now_ms = now;
		return it;
	endfunction

	function automatic req_item_t edge_req(input logic [1:0] cmd, input logic [1:0] pins);
		return mk_req(cmd, pins, 1'($urandom), $urandom);
	endfunction

	task automatic send_checked(input req_item_t it);
		offer(it, 1'b0, '0);
	endtask

	task automatic step_up();
		send_checked(edge_req(CMD_CLK_EDGE, PINS_CLK_ONLY));
		send_checked(edge_req(CMD_DATA_EDGE, PINS_BOTH));
	endtask

	task automatic step_down();
		send_checked(edge_req(CMD_DATA_EDGE, PINS_DATA_ONLY));
		send_checked(edge_req(CMD_CLK_EDGE, PINS_BOTH));
	endtask

	task automatic row(input logic [1:0] cmd, input logic [1:0] pins, input logic btn,
		input logic [TIME_W-1:0] now, input bit typed, input logic [1:0] ev, input int pos);
		dir_row_t r;
		r.req = mk_req(cmd, pins, btn, now);
		r.typed = typed;
		r.want.event_res = ev;
		r.want.position = pos[POS_W-1:0];
		dir_rows.push_back(r);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_rsp_q.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_window(input logic [DEBOUNCE_W-1:0] v);
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_phase(input int unsigned n_items);
		int unsigned stop_at;
		int unsigned pick;
		logic        btn;
		stop_at = req_sent + n_items;
		while (req_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				step_up();
			end else if (pick < 55) begin
				step_down();
			end else if (pick < 72) begin
				// scan times walk around the debounce window; now and then a jump
				if ($urandom_range(0, 15) == 0)
					scan_clock = $urandom;
				else
					scan_clock = scan_clock + $urandom_range(0, 2 * int'(window_ms) + 2);
				btn = ($urandom_range(0, 2) == 0);
				send_checked(mk_req(CMD_SCAN, 2'($urandom), btn, scan_clock));
			end else if (pick < 82) begin
				send_checked(edge_req(CMD_SWITCH, 2'($urandom)));
			end else begin
				send_checked(mk_req(2'($urandom), 2'($urandom), 1'($urandom), $urandom));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_item = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		window_ms = DEBOUNCE_RESET;
		pos_count = '0;
		want_clk_detent = 1'b0;
		want_data_detent = 1'b0;
		seen_pos = '0;
		last_low_ms = '0;
		switch_pend = 1'b0;

		//  cmd            pins            btn  now           typed event     pos
		row(CMD_SCAN,      2'b00,          1'b1, 32'd0,        1'b1, EV_NONE,  0);
		row(CMD_CLK_EDGE,  PINS_CLK_ONLY,  1'b1, 32'd0,        1'b1, EV_NONE,  0);
		row(CMD_DATA_EDGE, PINS_BOTH,      1'b0, 32'hFFFFFFFF, 1'b1, EV_NONE,  1);
		row(CMD_SCAN,      2'b00,          1'b1, 32'd0,        1'b1, EV_INC,   1);
		row(CMD_DATA_EDGE, PINS_DATA_ONLY, 1'b1, 32'd0,        1'b1, EV_NONE,  1);
		row(CMD_CLK_EDGE,  PINS_BOTH,      1'b1, 32'd0,        1'b1, EV_NONE,  0);
		row(CMD_SCAN,      PINS_BOTH,      1'b1, 32'hFFFFFFFF, 1'b1, EV_DEC,   0);
		// edges that match no detent pattern leave everything alone
		row(CMD_CLK_EDGE,  2'b00,          1'b1, 32'd0,        1'b1, EV_NONE,  0);
		row(CMD_CLK_EDGE,  PINS_DATA_ONLY, 1'b1, 32'd0,        1'b0, EV_NONE,  0);
		row(CMD_CLK_EDGE,  PINS_BOTH,      1'b1, 32'd0,        1'b0, EV_NONE,  0);
		row(CMD_DATA_EDGE, PINS_CLK_ONLY,  1'b0, 32'd0,        1'b0, EV_NONE,  0);
		row(CMD_DATA_EDGE, PINS_BOTH,      1'b1, 32'd0,        1'b0, EV_NONE,  0);
		row(CMD_DATA_EDGE, 2'b00,          1'b1, 32'd0,        1'b0, EV_NONE,  0);
		row(CMD_SCAN,      2'b00,          1'b1, 32'd0,        1'b0, EV_NONE,  0);
		row(CMD_DATA_EDGE, PINS_DATA_ONLY, 1'b1, 32'd0,        1'b0, EV_NONE,  0);
		row(CMD_CLK_EDGE,  PINS_BOTH,      1'b1, 32'd0,        1'b1, EV_NONE, -1);
		row(CMD_SCAN,      2'b00,          1'b1, 32'd0,        1'b1, EV_DEC,  -1);
		// press timing: equal to the window is not enough
		row(CMD_SWITCH,    PINS_BOTH,      1'b0, 32'hFFFFFFFF, 1'b1, EV_NONE, -1);
		row(CMD_SCAN,      2'b00,          1'b0, 32'd50,       1'b1, EV_NONE, -1);
		row(CMD_SCAN,      2'b00,          1'b0, 32'd101,      1'b1, EV_PRESS,-1);
		row(CMD_SCAN,      2'b00,          1'b0, 32'hFFFFFFFF, 1'b1, EV_NONE, -1);
		// press together with rotation, elapsed time across the 32-bit wrap
		row(CMD_SWITCH,    2'b00,          1'b1, 32'd0,        1'b1, EV_NONE, -1);
		row(CMD_CLK_EDGE,  PINS_CLK_ONLY,  1'b1, 32'd0,        1'b0, EV_NONE, -1);
		row(CMD_DATA_EDGE, PINS_BOTH,      1'b1, 32'd0,        1'b1, EV_NONE,  0);
		row(CMD_SCAN,      2'b00,          1'b0, 32'd50,       1'b1, EV_PRESS, 0);
		row(CMD_SCAN,      2'b00,          1'b1, 32'd0,        1'b1, EV_NONE,  0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gaps_on = 1'b1;
		foreach (dir_rows[i])
			offer(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
		drain();

		write_window('0);
		hold_long = 1'b1;
		random_phase(PHASE_ITEMS);
		drain();

		write_window('1);
		random_phase(PHASE_ITEMS);
		drain();

		write_window(16'($urandom_range(1, 400)));
		random_phase(PHASE_ITEMS);
		drain();

		gaps_on = 1'b0;
		write_window(16'($urandom));
		random_phase(PHASE_ITEMS);
		drain();

		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
